// ===== sv/dq_pkg.sv =====
// dq_pkg: shared constants for the double-ended queue
// operation and status codes, default sizes, empty-pop sentinel
// no dependencies
package dq_pkg;

  // default sizes
  localparam int unsigned DefDepth     = 64;
  localparam int unsigned DefDataWidth = 32;

  // fixed field widths
  localparam int unsigned ModeW   = 2;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;

  // operation codes
  localparam logic [ModeW-1:0] OpPushBack  = 2'd0;
  localparam logic [ModeW-1:0] OpPushFront = 2'd1;
  localparam logic [ModeW-1:0] OpPopBack   = 2'd2;
  localparam logic [ModeW-1:0] OpPopFront  = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StEmpty = 2'd1;
  localparam logic [StatusW-1:0] StFull  = 2'd2;

  // value returned by a pop on an empty queue
  localparam logic [ValueW-1:0] Sentinel = -32'sd9999999;

endpackage

// ===== sv/double_ended_queue.sv =====
// double_ended_queue: bounded deque in a circular synchronous memory
// depends on dq_pkg
//
// Usage:
//   Input words arrive on s_axis: tuser carries the operation (push back,
//   push front, pop back, pop front), tdata the value to push.
//   Every input word yields exactly one output word on m_axis: tuser holds
//   the status (ok, pop on empty, push on full), tdata the popped value,
//   the element count after the operation and an empty flag.
//   A pop on an empty queue returns the sentinel -9999999; a push on a
//   full queue is dropped and the queue is left as it was.
// Timing:
//   A word is accepted in the idle cycle, the memory is read or written
//   at that edge and the result is loaded into the output register on the
//   next edge if that register is free. The entry memory read is registered;
//   no new word is taken until the last result is in the output register.
// Reset and stall:
//   Reset empties the queue (pointers and count to zero); memory contents
//   are not cleared. While the receiver stalls, the result waits in the
//   output register; one more input word is taken and held until the
//   output register frees up.
module double_ended_queue #(
  parameter int unsigned DEPTH      = dq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = dq_pkg::DefDataWidth,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned OutRawW   = dq_pkg::ValueW + CntW + 1,
  localparam int unsigned OutW      = ((OutRawW + 7) / 8) * 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [dq_pkg::ValueW-1:0]  s_axis_tdata_i,   // value
  input  logic [dq_pkg::ModeW-1:0]   s_axis_tuser_i,   // mode
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [OutW-1:0]            m_axis_tdata_o,   // popped, count, empty_flag, zero pad
  output logic [dq_pkg::StatusW-1:0] m_axis_tuser_o    // status
);

  localparam int unsigned AddrW = $clog2(DEPTH);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(DEPTH);

  localparam logic StIdle = 1'b0;
  localparam logic StBusy = 1'b1;

  logic state_q, state_d;

  logic [AddrW-1:0] front_q, front_d, back_q, back_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [AddrW-1:0] front_up, front_dn, back_up, back_dn;

  logic                        in_acc;
  logic                        wr_en, rd_en;
  logic [AddrW-1:0]            wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0]       wr_data;
  logic [DATA_WIDTH+dq_pkg::ValueW-1:0] val_ext;
  logic [DATA_WIDTH-1:0]       mem [DEPTH];
  logic [DATA_WIDTH-1:0]       rd_q;
  logic [DATA_WIDTH+dq_pkg::ValueW-1:0] rd_ext;

  logic [dq_pkg::StatusW-1:0]  stat_d, stat_q;
  logic                        use_rd_q;
  logic                        load_out;
  logic [dq_pkg::ValueW-1:0]   popped;

  logic                        m_valid_q;
  logic [OutW-1:0]             m_data_q;
  logic [dq_pkg::StatusW-1:0]  m_user_q;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == StIdle);

  // circular pointer steps
  assign front_up = (front_q == LastAddr) ? '0 : front_q + 1'b1;
  assign front_dn = (front_q == '0) ? LastAddr : front_q - 1'b1;
  assign back_up  = (back_q == LastAddr) ? '0 : back_q + 1'b1;
  assign back_dn  = (back_q == '0) ? LastAddr : back_q - 1'b1;

  // value stored in its low bits, zero extended for wide entries
  assign val_ext = {{DATA_WIDTH{1'b0}}, s_axis_tdata_i};
  assign wr_data = val_ext[DATA_WIDTH-1:0];

  // operation decode and pointer update
  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    occ_d   = occ_q;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    wr_addr = back_q;
    rd_addr = front_q;
    stat_d  = dq_pkg::StOk;
    case (s_axis_tuser_i)
      dq_pkg::OpPushBack: begin
        if (occ_q == FullCnt) begin
          stat_d = dq_pkg::StFull;
        end else begin
          wr_en   = in_acc;
          wr_addr = back_q;
          back_d  = back_up;
          occ_d   = occ_q + 1'b1;
        end
      end
      dq_pkg::OpPushFront: begin
        if (occ_q == FullCnt) begin
          stat_d = dq_pkg::StFull;
        end else begin
          wr_en   = in_acc;
          wr_addr = front_dn;
          front_d = front_dn;
          occ_d   = occ_q + 1'b1;
        end
      end
      dq_pkg::OpPopBack: begin
        if (occ_q == '0) begin
          stat_d = dq_pkg::StEmpty;
        end else begin
          rd_en   = in_acc;
          rd_addr = back_dn;
          back_d  = back_dn;
          occ_d   = occ_q - 1'b1;
        end
      end
      dq_pkg::OpPopFront: begin
        if (occ_q == '0) begin
          stat_d = dq_pkg::StEmpty;
        end else begin
          rd_en   = in_acc;
          rd_addr = front_q;
          front_d = front_up;
          occ_d   = occ_q - 1'b1;
        end
      end
      default: begin
        stat_d = dq_pkg::StOk;
      end
    endcase
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // queue pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      occ_q   <= '0;
    end else if (in_acc) begin
      front_q <= front_d;
      back_q  <= back_d;
      occ_q   <= occ_d;
    end
  end

  // per-word result info carried to the output stage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      stat_q   <= stat_d;
      use_rd_q <= rd_en;
    end
  end

  // sequencer
  assign load_out = (state_q == StBusy) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          state_d = StBusy;
        end
      end
      StBusy: begin
        if (load_out) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // popped value: sign extended entry, sentinel or zero
  assign rd_ext = {{dq_pkg::ValueW{rd_q[DATA_WIDTH-1]}}, rd_q};

  always_comb begin
    if (use_rd_q) begin
      popped = rd_ext[dq_pkg::ValueW-1:0];
    end else if (stat_q == dq_pkg::StEmpty) begin
      popped = dq_pkg::Sentinel;
    end else begin
      popped = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= OutW'({(occ_q == '0), occ_q, popped});
      m_user_q <= stat_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

// ===== sv/dq_checker.sv =====
// dq_checker: port-level assertions for double_ended_queue, with bind
// depends on dq_pkg and double_ended_queue
module dq_checker #(
  parameter int unsigned DEPTH      = dq_pkg::DefDepth,
  parameter int unsigned DATA_WIDTH = dq_pkg::DefDataWidth,
  localparam int unsigned CntW      = $clog2(DEPTH + 1),
  localparam int unsigned OutRawW   = dq_pkg::ValueW + CntW + 1,
  localparam int unsigned OutW      = ((OutRawW + 7) / 8) * 8
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [OutW-1:0]            m_axis_tdata_o,
  input logic [dq_pkg::StatusW-1:0] m_axis_tuser_o
);

  localparam int unsigned CntLo = dq_pkg::ValueW;
  localparam int unsigned EmpB  = dq_pkg::ValueW + CntW;
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);
  localparam int unsigned DataWUsed = DATA_WIDTH;

  logic [CntW-1:0] cnt;
  logic            emp;

  assign cnt = m_axis_tdata_o[EmpB-1:CntLo];
  assign emp = m_axis_tdata_o[EmpB];

  // count never exceeds capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cnt <= FullCnt))
    else $error("count above depth (data width %0d)", DataWUsed);

  // empty flag tracks count
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (emp == (cnt == '0)))
    else $error("empty flag disagrees with count");

  // pop on empty gives sentinel and zero count
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == dq_pkg::StEmpty)) |->
      ((m_axis_tdata_o[dq_pkg::ValueW-1:0] == dq_pkg::Sentinel) && (cnt == '0)))
    else $error("empty pop result wrong");

  // rejected push only when full, nothing popped
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == dq_pkg::StFull)) |->
      ((cnt == FullCnt) && (m_axis_tdata_o[dq_pkg::ValueW-1:0] == '0)))
    else $error("full status with queue not full");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled output word changed");

endmodule

bind double_ended_queue dq_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== dv/tb_double_ended_queue.sv =====
// tb_double_ended_queue: self-checking bench for the double-ended queue
// drives words on s_axis, tracks queue contents in a scoreboard, checks m_axis
// depends on dq_pkg and double_ended_queue
module tb_double_ended_queue;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDepth = dq_pkg::DefDepth;
  localparam int unsigned CntW   = $clog2(QDepth + 1);
  localparam int unsigned OutRawW = dq_pkg::ValueW + CntW + 1;
  localparam int unsigned OutW   = ((OutRawW + 7) / 8) * 8;
  localparam int unsigned PtrW   = $clog2(QDepth);
  localparam int unsigned NumRandom = 1150;

  // expected contents of one result word
  typedef struct packed {
    logic [dq_pkg::ValueW-1:0]  popped;
    logic [dq_pkg::StatusW-1:0] status;
    logic [CntW-1:0]            count;
    logic                       empty_flag;
  } deque_result_t;

  // mirror of the queue and the results still owed by the block
  class deque_tracker;
    logic [dq_pkg::ValueW-1:0] slots [QDepth];
    logic [PtrW-1:0]   head_idx;
    logic [PtrW-1:0]   tail_idx;
    int unsigned       fill;
    deque_result_t     owed_q [$];
    int unsigned       err_cnt;

    function new();
      head_idx = '0;
      tail_idx = '0;
      fill     = 0;
      err_cnt  = 0;
    endfunction

    // apply one accepted word to the mirror and queue up its result
    function void note_word(logic [dq_pkg::ModeW-1:0] mode,
                            logic [dq_pkg::ValueW-1:0] value);
      deque_result_t res;
      res.popped = '0;
      res.status = dq_pkg::StOk;
      if (mode == dq_pkg::OpPushBack || mode == dq_pkg::OpPushFront) begin
        if (fill >= QDepth) begin
          res.status = dq_pkg::StFull;
        end else if (mode == dq_pkg::OpPushBack) begin
          slots[tail_idx] = value;
          tail_idx = tail_idx + 1'b1;
          fill++;
        end else begin
          head_idx = head_idx - 1'b1;
          slots[head_idx] = value;
          fill++;
        end
      end else begin
        if (fill == 0) begin
          res.status = dq_pkg::StEmpty;
          res.popped = dq_pkg::Sentinel;
        end else if (mode == dq_pkg::OpPopBack) begin
          tail_idx = tail_idx - 1'b1;
          res.popped = slots[tail_idx];
          fill--;
        end else begin
          res.popped = slots[head_idx];
          head_idx = head_idx + 1'b1;
          fill--;
        end
      end
      res.count      = CntW'(fill);
      res.empty_flag = (fill == 0);
      owed_q.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_cnt++;
    endtask

    // compare one result word with the oldest owed result
    task check_word(logic [OutW-1:0] data, logic [dq_pkg::StatusW-1:0] status);
      deque_result_t exp_res;
      logic [dq_pkg::ValueW-1:0] got_popped;
      logic [CntW-1:0]   got_count;
      logic              got_empty;
      got_popped = data[dq_pkg::ValueW-1:0];
      got_count  = data[dq_pkg::ValueW +: CntW];
      got_empty  = data[dq_pkg::ValueW + CntW];
      if (owed_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word data=%h status=%0d", data, status));
      end else begin
        exp_res = owed_q.pop_front();
        if (got_popped !== exp_res.popped)
          flag_mismatch($sformatf("popped %h, want %h", got_popped, exp_res.popped));
        if (status !== exp_res.status)
          flag_mismatch($sformatf("status %0d, want %0d", status, exp_res.status));
        if (got_count !== exp_res.count)
          flag_mismatch($sformatf("count %0d, want %0d", got_count, exp_res.count));
        if (got_empty !== exp_res.empty_flag)
          flag_mismatch($sformatf("empty_flag %b, want %b", got_empty, exp_res.empty_flag));
        if ((data >> OutRawW) !== '0)
          flag_mismatch($sformatf("nonzero pad bits in %h", data));
      end
    endtask

    function int unsigned owed();
      return owed_q.size();
    endfunction
  endclass

  logic                        clk_i;
  logic                        rst_ni;
  logic                        s_axis_tvalid_i;
  logic                        s_axis_tready_o;
  logic [dq_pkg::ValueW-1:0]   s_axis_tdata_i;   // value
  logic [dq_pkg::ModeW-1:0]    s_axis_tuser_i;   // mode
  logic                        m_axis_tvalid_o;
  logic                        m_axis_tready_i;
  logic [OutW-1:0]             m_axis_tdata_o;   // popped, count, empty_flag, zero pad
  logic [dq_pkg::StatusW-1:0]  m_axis_tuser_o;   // status

  deque_tracker tracker;
  int unsigned  src_idle_pct;
  int unsigned  sink_idle_pct;
  int unsigned  sink_hold_cycles;
  int unsigned  words_sent;

  double_ended_queue u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // watchdog
  initial begin
    #2_000_000;
    $display("tb_double_ended_queue: FAIL");
    $finish;
  end

  // offer one word, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_word(logic [dq_pkg::ModeW-1:0] mode, logic [dq_pkg::ValueW-1:0] value);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_word(mode, value);
    words_sent++;
    // idling plan: sender light / receiver heavy, then swapped, then none
    if (words_sent < 380) begin
      src_idle_pct  = 18;
      sink_idle_pct = 62;
    end else if (words_sent < 760) begin
      src_idle_pct  = 62;
      sink_idle_pct = 18;
    end else begin
      src_idle_pct  = 0;
      sink_idle_pct = 0;
    end
  endtask

  function automatic logic [dq_pkg::ValueW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'hffff_ffff;
      3:       return dq_pkg::Sentinel;
      default: return $urandom;
    endcase
  endfunction

  // receiver: check accepted words, then choose next tready
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_word(m_axis_tdata_o, m_axis_tuser_o);
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // stimulus
  initial begin
    logic [dq_pkg::ModeW-1:0] mode;
    int unsigned      seg_len;
    int unsigned      push_pct;
    int unsigned      rand_sent;
    bit               held;

    tracker          = new();
    src_idle_pct     = 18;
    sink_idle_pct    = 62;
    sink_hold_cycles = 0;
    words_sent       = 0;
    rand_sent        = 0;
    held             = 1'b0;
    rst_ni           = 1'b0;
    s_axis_tvalid_i  = 1'b0;
    s_axis_tdata_i   = '0;
    s_axis_tuser_i   = dq_pkg::OpPushBack;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pops on empty, extreme values, every op, last-element pops, wrap
    send_word(dq_pkg::OpPopBack,   32'h1234_5678);
    send_word(dq_pkg::OpPopFront,  32'hffff_ffff);
    send_word(dq_pkg::OpPushBack,  32'h7fff_ffff);
    send_word(dq_pkg::OpPushFront, 32'h8000_0000);
    send_word(dq_pkg::OpPushBack,  32'hffff_ffff);
    send_word(dq_pkg::OpPushFront, 32'h0000_0000);
    send_word(dq_pkg::OpPushBack,  dq_pkg::Sentinel);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPopBack,   32'h0);
    send_word(dq_pkg::OpPopBack,   32'h0);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPushFront, 32'h5555_5555);
    send_word(dq_pkg::OpPopBack,   32'h0);
    send_word(dq_pkg::OpPushFront, 32'haaaa_aaaa);
    send_word(dq_pkg::OpPushFront, 32'h0000_0001);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPopFront,  32'h0);
    send_word(dq_pkg::OpPopBack,   32'h0);

    // random: segments with a biased push rate so the queue swings between empty and full
    while (rand_sent < NumRandom) begin
      seg_len = $urandom_range(120, 40);
      if (seg_len > NumRandom - rand_sent)
        seg_len = NumRandom - rand_sent;
      case ($urandom_range(5))
        0:       push_pct = 100;
        1:       push_pct = 90;
        2, 3:    push_pct = 50;
        4:       push_pct = 10;
        default: push_pct = 0;
      endcase
      repeat (seg_len) begin
        if ($urandom_range(99) < push_pct)
          mode = $urandom_range(1) ? dq_pkg::OpPushFront : dq_pkg::OpPushBack;
        else
          mode = $urandom_range(1) ? dq_pkg::OpPopFront : dq_pkg::OpPopBack;
        send_word(mode, pick_value());
        rand_sent++;
        // long receiver stall while the sender keeps offering words
        if (!held && words_sent >= 900) begin
          held = 1'b1;
          sink_hold_cycles = 200;
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // drain, then allow for any stray word
    while (tracker.owed() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.err_cnt == 0)
      $display("tb_double_ended_queue: PASS");
    else
      $display("tb_double_ended_queue: FAIL");
    $finish;
  end

endmodule
